>>> sv/nkrt_pkg.sv
// Package for the name-keyed record table.
// Record type, field widths, operation and status codes. No dependencies.
package nkrt_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int HEAD_W          = 64;
	localparam int TAIL_W          = 8;
	localparam int SLOT_W          = 6;
	localparam int CNT_W           = 7;
	localparam int FUNC_W          = 2;
	localparam int STAT_W          = 2;

	localparam logic [FUNC_W-1:0] FN_ADD  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DEL  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FIND = 2'd2;
	localparam logic [FUNC_W-1:0] FN_LIST = 2'd3;

	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd2;

	typedef struct packed {
		logic [HEAD_W-1:0] name_head;
		logic [TAIL_W-1:0] name_tail;
		logic [HEAD_W-1:0] second_head;
		logic [TAIL_W-1:0] second_tail;
		logic [HEAD_W-1:0] phone_head;
		logic [TAIL_W-1:0] phone_tail;
	} rec_t;

endpackage

>>> sv/nkrt_mem.sv
// Record memory: one synchronous (registered) read port, one write port.
// Per-entry valid bits cleared at reset; an invalid entry reads as zero.
// Depends on nkrt_pkg.
module nkrt_mem #(
	parameter int DEPTH = nkrt_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] raddr,
	output nkrt_pkg::rec_t rdata,
	input  logic          we,
	input  logic          clr,
	input  logic [AW-1:0] waddr,
	input  nkrt_pkg::rec_t wdata
);

	nkrt_pkg::rec_t mem [DEPTH];
	nkrt_pkg::rec_t rd_q;
	logic [DEPTH-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[raddr];
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end else if (clr) begin
				vld_q[waddr] <= 1'b0;
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

>>> sv/nkrt_ctrl.sv
// Sequencer for the record table: match scan pass, emit pass, add write,
// used-slot count and the result register. Depends on nkrt_pkg.
module nkrt_ctrl #(
	parameter int DEPTH = nkrt_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [nkrt_pkg::FUNC_W-1:0]   func,
	input  nkrt_pkg::rec_t                key,
	output logic [AW-1:0]                 mem_raddr,
	input  nkrt_pkg::rec_t                mem_rdata,
	output logic                          mem_we,
	output logic                          mem_clr,
	output logic [AW-1:0]                 mem_waddr,
	output nkrt_pkg::rec_t                mem_wdata,
	output logic                          result_valid,
	output logic [nkrt_pkg::SLOT_W-1:0]   slot_index,
	output nkrt_pkg::rec_t                rec,
	output logic                          record_valid,
	output logic [nkrt_pkg::STAT_W-1:0]   status,
	output logic [nkrt_pkg::CNT_W-1:0]    used_count,
	output logic                          last
);

	localparam logic [1:0] SQ_IDLE = 2'd0;
	localparam logic [1:0] SQ_SCAN = 2'd1;
	localparam logic [1:0] SQ_EMIT = 2'd2;
	localparam logic [1:0] SQ_FIN  = 2'd3;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [1:0]                  state_q;
	logic [nkrt_pkg::FUNC_W-1:0] func_q;
	nkrt_pkg::rec_t              key_q;
	logic [AW-1:0]               addr_q;
	logic                        issue_q;
	logic                        vld_s1;
	logic [AW-1:0]               idx_s1;
	logic [DEPTH-1:0]            match_q;
	logic [AW:0]                 mcnt_q;
	logic [AW:0]                 rem_q;
	logic                        free_found_q;
	logic [AW-1:0]               free_idx_q;
	logic [nkrt_pkg::CNT_W-1:0]  cnt_q;

	logic                        res_stb_q;
	logic [nkrt_pkg::SLOT_W-1:0] slot_q;
	nkrt_pkg::rec_t              rec_q;
	logic                        rvalid_q;
	logic [nkrt_pkg::STAT_W-1:0] status_q;
	logic [nkrt_pkg::CNT_W-1:0]  used_q;
	logic                        last_q;

	logic                        accept;
	logic                        hit;
	logic                        is_free;
	logic [AW:0]                 mcnt_nx;
	logic                        key_used;
	logic                        emit_hit;

	assign accept    = start && (state_q == SQ_IDLE);
	assign busy      = (state_q != SQ_IDLE);
	assign hit       = (mem_rdata.name_head == key_q.name_head) &&
	                   (mem_rdata.name_tail == key_q.name_tail);
	assign is_free   = (mem_rdata.name_head[nkrt_pkg::HEAD_W-1 -: 8] == 8'd0);
	assign mcnt_nx   = mcnt_q + (AW+1)'(hit);
	assign key_used  = (key_q.name_head[nkrt_pkg::HEAD_W-1 -: 8] != 8'd0);
	assign emit_hit  = (state_q == SQ_EMIT) && vld_s1 && match_q[idx_s1];

	assign mem_raddr = addr_q;
	assign mem_wdata = key_q;
	assign mem_we    = (state_q == SQ_FIN) && (func_q == nkrt_pkg::FN_ADD) && free_found_q;
	assign mem_clr   = emit_hit && (func_q == nkrt_pkg::FN_DEL);
	assign mem_waddr = (state_q == SQ_FIN) ? free_idx_q : idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SQ_IDLE;
			issue_q      <= 1'b0;
			vld_s1       <= 1'b0;
			free_found_q <= 1'b0;
			cnt_q        <= '0;
			res_stb_q    <= 1'b0;
		end else begin
			vld_s1    <= issue_q;
			if (issue_q) begin
				issue_q <= (addr_q != LAST_IDX);
			end
			unique case (state_q)
				SQ_IDLE: begin
					res_stb_q <= 1'b0;
					if (accept) begin
						issue_q      <= 1'b1;
						free_found_q <= 1'b0;
						state_q      <= (func == nkrt_pkg::FN_LIST) ? SQ_EMIT : SQ_SCAN;
					end
				end
				SQ_SCAN: begin
					res_stb_q <= 1'b0;
					if (vld_s1) begin
						if (!free_found_q && is_free) begin
							free_found_q <= 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							if (func_q == nkrt_pkg::FN_ADD || mcnt_nx == '0) begin
								state_q <= SQ_FIN;
							end else begin
								state_q <= SQ_EMIT;
								issue_q <= 1'b1;
								if (func_q == nkrt_pkg::FN_DEL && key_used) begin
									cnt_q <= cnt_q - nkrt_pkg::CNT_W'(mcnt_nx);
								end
							end
						end
					end
				end
				SQ_EMIT: begin
					res_stb_q <= emit_hit;
					if (vld_s1 && idx_s1 == LAST_IDX) begin
						state_q <= SQ_IDLE;
					end
				end
				SQ_FIN: begin
					res_stb_q <= 1'b1;
					state_q   <= SQ_IDLE;
					if (mem_we && key_used) begin
						cnt_q <= cnt_q + nkrt_pkg::CNT_W'(1);
					end
				end
				default: begin
					res_stb_q <= 1'b0;
					state_q   <= SQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue_q) begin
			idx_s1 <= addr_q;
			if (addr_q != LAST_IDX) begin
				addr_q <= addr_q + AW'(1);
			end
		end
		unique case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					func_q           <= func;
					key_q            <= key;
					addr_q           <= '0;
					mcnt_q           <= '0;
					match_q          <= (func == nkrt_pkg::FN_LIST) ? '1 : '0;
					rem_q            <= (AW+1)'(DEPTH);
				end
			end
			SQ_SCAN: begin
				if (vld_s1) begin
					match_q[idx_s1] <= hit;
					mcnt_q          <= mcnt_nx;
					if (!free_found_q && is_free) begin
						free_idx_q <= idx_s1;
					end
					if (idx_s1 == LAST_IDX) begin
						addr_q <= '0;
						rem_q  <= mcnt_nx;
					end
				end
			end
			SQ_EMIT: begin
				if (emit_hit) begin
					rem_q    <= rem_q - (AW+1)'(1);
					slot_q   <= nkrt_pkg::SLOT_W'(idx_s1);
					rec_q    <= mem_rdata;
					rvalid_q <= 1'b1;
					status_q <= nkrt_pkg::STAT_DONE;
					used_q   <= cnt_q;
					last_q   <= (rem_q == (AW+1)'(1));
				end
			end
			SQ_FIN: begin
				last_q <= 1'b1;
				if (mem_we) begin
					slot_q   <= nkrt_pkg::SLOT_W'(free_idx_q);
					rec_q    <= key_q;
					rvalid_q <= 1'b1;
					status_q <= nkrt_pkg::STAT_DONE;
					used_q   <= key_used ? cnt_q + nkrt_pkg::CNT_W'(1) : cnt_q;
				end else begin
					slot_q   <= '0;
					rec_q    <= '0;
					rvalid_q <= 1'b0;
					status_q <= (func_q == nkrt_pkg::FN_ADD) ? nkrt_pkg::STAT_FULL
					                                          : nkrt_pkg::STAT_NOMATCH;
					used_q   <= cnt_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = res_stb_q;
	assign slot_index   = slot_q;
	assign rec          = rec_q;
	assign record_valid = rvalid_q;
	assign status       = status_q;
	assign used_count   = used_q;
	assign last         = last_q;

endmodule

>>> sv/name_keyed_record_table_core.sv
// Name-keyed record table: add, delete, find and list over a slot memory.
// Add: one scan pass over TABLE_DEPTH slots, then one write if a free slot was found.
// Delete/find: a match scan pass, then an emit pass if there were matches. List: one emit pass.
// One memory read per cycle sets the pace. Results leave on result_valid for one cycle each;
// the receiver cannot stall.
// Reset clears all slot valid bits and the used count; every slot reads as empty afterwards.
module name_keyed_record_table_core #(
	parameter int TABLE_DEPTH = nkrt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [nkrt_pkg::FUNC_W-1:0]         func,
	input  logic [nkrt_pkg::HEAD_W-1:0]         key_name_head,
	input  logic [nkrt_pkg::TAIL_W-1:0]         key_name_tail,
	input  logic [nkrt_pkg::HEAD_W-1:0]         new_second_head,
	input  logic [nkrt_pkg::TAIL_W-1:0]         new_second_tail,
	input  logic [nkrt_pkg::HEAD_W-1:0]         new_phone_head,
	input  logic [nkrt_pkg::TAIL_W-1:0]         new_phone_tail,
	output logic                                result_valid,
	output logic [nkrt_pkg::SLOT_W-1:0]         slot_index,
	output logic [nkrt_pkg::HEAD_W-1:0]         rec_name_head,
	output logic [nkrt_pkg::TAIL_W-1:0]         rec_name_tail,
	output logic [nkrt_pkg::HEAD_W-1:0]         rec_second_head,
	output logic [nkrt_pkg::TAIL_W-1:0]         rec_second_tail,
	output logic [nkrt_pkg::HEAD_W-1:0]         rec_phone_head,
	output logic [nkrt_pkg::TAIL_W-1:0]         rec_phone_tail,
	output logic                                record_valid,
	output logic [nkrt_pkg::STAT_W-1:0]         status,
	output logic [nkrt_pkg::CNT_W-1:0]          used_count,
	output logic                                last
);

	localparam int AW = $clog2(TABLE_DEPTH);

	nkrt_pkg::rec_t key;
	nkrt_pkg::rec_t rec;
	nkrt_pkg::rec_t mem_rdata;
	nkrt_pkg::rec_t mem_wdata;
	logic [AW-1:0]  mem_raddr;
	logic [AW-1:0]  mem_waddr;
	logic           mem_we;
	logic           mem_clr;

	assign key.name_head   = key_name_head;
	assign key.name_tail   = key_name_tail;
	assign key.second_head = new_second_head;
	assign key.second_tail = new_second_tail;
	assign key.phone_head  = new_phone_head;
	assign key.phone_tail  = new_phone_tail;

	nkrt_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata),
		.we     (mem_we),
		.clr    (mem_clr),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata)
	);

	nkrt_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.key          (key),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.mem_we       (mem_we),
		.mem_clr      (mem_clr),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.result_valid (result_valid),
		.slot_index   (slot_index),
		.rec          (rec),
		.record_valid (record_valid),
		.status       (status),
		.used_count   (used_count),
		.last         (last)
	);

	assign rec_name_head   = rec.name_head;
	assign rec_name_tail   = rec.name_tail;
	assign rec_second_head = rec.second_head;
	assign rec_second_tail = rec.second_tail;
	assign rec_phone_head  = rec.phone_head;
	assign rec_phone_tail  = rec.phone_tail;

endmodule
